// ===== hdl/ler_pkg.sv =====
// Shared types, register codes and width helpers for the line endpoint rotator.
`default_nettype none
package ler_pkg;

    localparam int TRIG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MID_W     = 48;
    localparam int NUM_PTS   = 2;
    localparam int NUM_COORD = 6;

    localparam logic [CFG_IDX_W-1:0] REG_COS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Z = 3'd5;

    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;

    localparam logic signed [MID_W-1:0] MID_HI = {1'b0, {(MID_W-1){1'b1}}};
    localparam logic signed [MID_W-1:0] MID_LO = {1'b1, {(MID_W-2){1'b0}}, 1'b1};

    typedef struct packed {
        logic [TRIG_W-1:0] c;
        logic [TRIG_W-1:0] s;
    } t_trig;

    function automatic int sum_w(input int in_w);
        return in_w + TRIG_W + 1;
    endfunction

    function automatic int stage_out_w(input int in_w, input int frac);
        int sw;
        int sh;
        int ow;
        sw = sum_w(in_w);
        sh = (sw > frac) ? sw - frac : 1;
        ow = (sh > MID_W) ? MID_W : sh;
        return (ow > in_w) ? ow : in_w;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ler_seg_if.sv =====
// Request channel carrying one line segment as two 3D endpoints.
`default_nettype none
interface ler_seg_if #(
    parameter int W = 19
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] start_z;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;
    logic signed [W-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/ler_rot_if.sv =====
// Result channel carrying the rotated, saturated segment and its clip flag.
`default_nettype none
interface ler_rot_if #(
    parameter int W = 20
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rot_start_x;
    logic signed [W-1:0] rot_start_y;
    logic signed [W-1:0] rot_start_z;
    logic signed [W-1:0] rot_end_x;
    logic signed [W-1:0] rot_end_y;
    logic signed [W-1:0] rot_end_z;
    logic                clipped;

    modport source (output valid, rot_start_x, rot_start_y, rot_start_z,
                    rot_end_x, rot_end_y, rot_end_z, clipped, input ready);
    modport sink (input valid, rot_start_x, rot_start_y, rot_start_z,
                  rot_end_x, rot_end_y, rot_end_z, clipped, output ready);
endinterface
`default_nettype wire

// ===== hdl/ler_rot_cell.sv =====
// Plane rotation cell: products in one register level, sums and shift in the next.
`default_nettype none
module ler_rot_cell #(
    parameter int IN_W = 19,
    parameter int FRAC = 14,
    localparam int OUT_W = ler_pkg::stage_out_w(IN_W, FRAC)
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  ler_pkg::t_trig      i_trig,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  signed [IN_W-1:0]    i_a [ler_pkg::NUM_PTS],
    input  wire  signed [IN_W-1:0]    i_b [ler_pkg::NUM_PTS],
    input  wire  signed [IN_W-1:0]    i_p [ler_pkg::NUM_PTS],
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic signed [OUT_W-1:0]   o_a [ler_pkg::NUM_PTS],
    output logic signed [OUT_W-1:0]   o_b [ler_pkg::NUM_PTS],
    output logic signed [OUT_W-1:0]   o_p [ler_pkg::NUM_PTS]
);

    localparam int PROD_W = IN_W + ler_pkg::TRIG_W;
    localparam int SUM_W  = ler_pkg::sum_w(IN_W);
    localparam int CMP_W  = (SUM_W > ler_pkg::MID_W) ? SUM_W : ler_pkg::MID_W;

    logic                     r_v0;
    logic                     r_v1;
    logic signed [PROD_W-1:0] r_ac [ler_pkg::NUM_PTS];
    logic signed [PROD_W-1:0] r_bs [ler_pkg::NUM_PTS];
    logic signed [PROD_W-1:0] r_as [ler_pkg::NUM_PTS];
    logic signed [PROD_W-1:0] r_bc [ler_pkg::NUM_PTS];
    logic signed [IN_W-1:0]   r_p0 [ler_pkg::NUM_PTS];
    logic signed [OUT_W-1:0]  r_a1 [ler_pkg::NUM_PTS];
    logic signed [OUT_W-1:0]  r_b1 [ler_pkg::NUM_PTS];
    logic signed [OUT_W-1:0]  r_p1 [ler_pkg::NUM_PTS];
    logic signed [OUT_W-1:0]  n_a1 [ler_pkg::NUM_PTS];
    logic signed [OUT_W-1:0]  n_b1 [ler_pkg::NUM_PTS];
    logic signed [PROD_W-1:0] w_c;
    logic signed [PROD_W-1:0] w_s;
    logic                     w_adv0;
    logic                     w_adv1;

    // Floor shift, then hold the value inside the intermediate range.
    function automatic logic signed [OUT_W-1:0] fit(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] sh;
        sh = v >>> FRAC;
        if (CMP_W'(sh) > CMP_W'(ler_pkg::MID_HI)) begin
            sh = SUM_W'(ler_pkg::MID_HI);
        end else if (CMP_W'(sh) < CMP_W'(ler_pkg::MID_LO)) begin
            sh = SUM_W'(ler_pkg::MID_LO);
        end
        return sh[OUT_W-1:0];
    endfunction

    assign w_adv1  = !r_v1 || i_ready;
    assign w_adv0  = !r_v0 || w_adv1;
    assign o_ready = w_adv0;
    assign o_valid = r_v1;
    assign w_c     = PROD_W'($signed(i_trig.c));
    assign w_s     = PROD_W'($signed(i_trig.s));

    always_comb begin
        for (int e = 0; e < ler_pkg::NUM_PTS; e++) begin
            n_a1[e] = fit(SUM_W'(r_ac[e]) - SUM_W'(r_bs[e]));
            n_b1[e] = fit(SUM_W'(r_as[e]) + SUM_W'(r_bc[e]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_adv0) begin
                r_v0 <= i_valid;
            end
            if (w_adv1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < ler_pkg::NUM_PTS; e++) begin
            if (w_adv0) begin
                r_ac[e] <= PROD_W'(i_a[e]) * w_c;
                r_bs[e] <= PROD_W'(i_b[e]) * w_s;
                r_as[e] <= PROD_W'(i_a[e]) * w_s;
                r_bc[e] <= PROD_W'(i_b[e]) * w_c;
                r_p0[e] <= i_p[e];
            end
            if (w_adv1) begin
                r_a1[e] <= n_a1[e];
                r_b1[e] <= n_b1[e];
                r_p1[e] <= OUT_W'(r_p0[e]);
            end
        end
    end

    assign o_a = r_a1;
    assign o_b = r_b1;
    assign o_p = r_p1;

endmodule
`default_nettype wire

// ===== hdl/ler_sat_cell.sv =====
// Output cell: saturates six coordinates, forms the clip flag and holds the result.
`default_nettype none
module ler_sat_cell #(
    parameter int IN_W  = 25,
    parameter int OUT_W = 20
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  signed [IN_W-1:0]   i_c [ler_pkg::NUM_COORD],
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic signed [OUT_W-1:0]  o_c [ler_pkg::NUM_COORD],
    output logic                     o_clip
);

    localparam int CMP_W = (IN_W > OUT_W) ? IN_W : OUT_W;
    localparam logic signed [OUT_W-1:0] OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};

    logic                    r_v;
    logic                    r_clip;
    logic signed [OUT_W-1:0] r_c [ler_pkg::NUM_COORD];
    logic signed [OUT_W-1:0] n_c [ler_pkg::NUM_COORD];
    logic                    n_clip;
    logic                    w_adv;

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v;
    assign o_c     = r_c;
    assign o_clip  = r_clip;

    always_comb begin
        n_clip = 1'b0;
        for (int k = 0; k < ler_pkg::NUM_COORD; k++) begin
            if (CMP_W'(i_c[k]) > CMP_W'(OUT_HI)) begin
                n_c[k] = OUT_HI;
                n_clip = 1'b1;
            end else if (CMP_W'(i_c[k]) < CMP_W'(OUT_LO)) begin
                n_c[k] = OUT_LO;
                n_clip = 1'b1;
            end else begin
                n_c[k] = OUT_W'(CMP_W'(i_c[k]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c    <= n_c;
            r_clip <= n_clip;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/line_endpoint_rotate_xyz.sv =====
// Top level: rotates both endpoints of a 3D segment about X, then Y, then Z.
// A request on i_seg carries two signed endpoints; the rotated endpoints
// come out on o_rot, saturated to one bit more than the input width, with
// clipped set when any coordinate hit a rail.
// The six cosine and sine registers (Q2.14, indices 0 to 5 in the order
// cos X, sin X, cos Y, sin Y, cos Z, sin Z) are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while no request
// is in flight, as the block itself does not enforce it. The datapath is a
// row of three plane rotation cells and one saturation cell: each rotation
// cell holds a product and a sum register, the saturation cell one output
// register. Throughput is one request per cycle while o_rot is ready.
// Each register level advances when it is empty or the level after it
// advances, so when o_rot is stalled the block keeps taking requests until
// all seven levels hold data.
// Reset empties the row and returns the registers to the identity rotation.
`default_nettype none
module line_endpoint_rotate_xyz #(
    parameter int COORD_BITS     = 19,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [ler_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [ler_pkg::TRIG_W-1:0]         i_cfg_data,
    ler_seg_if.sink                            i_seg,
    ler_rot_if.source                          o_rot
);

    localparam int OUT_BITS = COORD_BITS + 1;
    localparam int W1 = ler_pkg::stage_out_w(COORD_BITS, TRIG_FRAC_BITS);
    localparam int W2 = ler_pkg::stage_out_w(W1, TRIG_FRAC_BITS);
    localparam int W3 = ler_pkg::stage_out_w(W2, TRIG_FRAC_BITS);
    localparam logic signed [OUT_BITS-1:0] OUT_HI = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OUT_LO = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic signed [ler_pkg::TRIG_W-1:0] r_cos [3];
    logic signed [ler_pkg::TRIG_W-1:0] r_sin [3];
    ler_pkg::t_trig                    w_trig [3];

    logic signed [COORD_BITS-1:0] s0_a [ler_pkg::NUM_PTS];
    logic signed [COORD_BITS-1:0] s0_b [ler_pkg::NUM_PTS];
    logic signed [COORD_BITS-1:0] s0_p [ler_pkg::NUM_PTS];
    logic signed [W1-1:0]         s1_a [ler_pkg::NUM_PTS];
    logic signed [W1-1:0]         s1_b [ler_pkg::NUM_PTS];
    logic signed [W1-1:0]         s1_p [ler_pkg::NUM_PTS];
    logic signed [W2-1:0]         s2_a [ler_pkg::NUM_PTS];
    logic signed [W2-1:0]         s2_b [ler_pkg::NUM_PTS];
    logic signed [W2-1:0]         s2_p [ler_pkg::NUM_PTS];
    logic signed [W3-1:0]         s3_a [ler_pkg::NUM_PTS];
    logic signed [W3-1:0]         s3_b [ler_pkg::NUM_PTS];
    logic signed [W3-1:0]         s3_p [ler_pkg::NUM_PTS];
    logic signed [W3-1:0]         s3_c [ler_pkg::NUM_COORD];
    logic signed [OUT_BITS-1:0]   w_out [ler_pkg::NUM_COORD];

    logic w_v1;
    logic w_v2;
    logic w_v3;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cos[k] <= ler_pkg::COS_RESET;
                r_sin[k] <= ler_pkg::SIN_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ler_pkg::REG_COS_X: r_cos[0] <= i_cfg_data;
                ler_pkg::REG_SIN_X: r_sin[0] <= i_cfg_data;
                ler_pkg::REG_COS_Y: r_cos[1] <= i_cfg_data;
                ler_pkg::REG_SIN_Y: r_sin[1] <= i_cfg_data;
                ler_pkg::REG_COS_Z: r_cos[2] <= i_cfg_data;
                ler_pkg::REG_SIN_Z: r_sin[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_trig[k].c = r_cos[k];
            w_trig[k].s = r_sin[k];
        end
    end

    // About X the plane is (y, z); about Y it is (z, x); about Z it is (x, y).
    assign s0_a[0] = i_seg.start_y;
    assign s0_b[0] = i_seg.start_z;
    assign s0_p[0] = i_seg.start_x;
    assign s0_a[1] = i_seg.end_y;
    assign s0_b[1] = i_seg.end_z;
    assign s0_p[1] = i_seg.end_x;

    ler_rot_cell #(.IN_W(COORD_BITS), .FRAC(TRIG_FRAC_BITS)) u_cell_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trig  (w_trig[0]),
        .i_valid (i_seg.valid),
        .o_ready (i_seg.ready),
        .i_a     (s0_a),
        .i_b     (s0_b),
        .i_p     (s0_p),
        .o_valid (w_v1),
        .i_ready (w_rdy1),
        .o_a     (s1_p),
        .o_b     (s1_a),
        .o_p     (s1_b)
    );

    ler_rot_cell #(.IN_W(W1), .FRAC(TRIG_FRAC_BITS)) u_cell_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trig  (w_trig[1]),
        .i_valid (w_v1),
        .o_ready (w_rdy1),
        .i_a     (s1_a),
        .i_b     (s1_b),
        .i_p     (s1_p),
        .o_valid (w_v2),
        .i_ready (w_rdy2),
        .o_a     (s2_p),
        .o_b     (s2_a),
        .o_p     (s2_b)
    );

    ler_rot_cell #(.IN_W(W2), .FRAC(TRIG_FRAC_BITS)) u_cell_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trig  (w_trig[2]),
        .i_valid (w_v2),
        .o_ready (w_rdy2),
        .i_a     (s2_a),
        .i_b     (s2_b),
        .i_p     (s2_p),
        .o_valid (w_v3),
        .i_ready (w_rdy3),
        .o_a     (s3_a),
        .o_b     (s3_b),
        .o_p     (s3_p)
    );

    assign s3_c[0] = s3_a[0];
    assign s3_c[1] = s3_b[0];
    assign s3_c[2] = s3_p[0];
    assign s3_c[3] = s3_a[1];
    assign s3_c[4] = s3_b[1];
    assign s3_c[5] = s3_p[1];

    ler_sat_cell #(.IN_W(W3), .OUT_W(OUT_BITS)) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_rdy3),
        .i_c     (s3_c),
        .o_valid (o_rot.valid),
        .i_ready (o_rot.ready),
        .o_c     (w_out),
        .o_clip  (o_rot.clipped)
    );

    assign o_rot.rot_start_x = w_out[0];
    assign o_rot.rot_start_y = w_out[1];
    assign o_rot.rot_start_z = w_out[2];
    assign o_rot.rot_end_x   = w_out[3];
    assign o_rot.rot_end_y   = w_out[4];
    assign o_rot.rot_end_z   = w_out[5];

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rot.valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rot.valid |-> i_seg.ready)
        else $error("request refused while the output register is empty");

    a_clip_on_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rot.valid && o_rot.clipped |->
            o_rot.rot_start_x == OUT_HI || o_rot.rot_start_x == OUT_LO ||
            o_rot.rot_start_y == OUT_HI || o_rot.rot_start_y == OUT_LO ||
            o_rot.rot_start_z == OUT_HI || o_rot.rot_start_z == OUT_LO ||
            o_rot.rot_end_x == OUT_HI || o_rot.rot_end_x == OUT_LO ||
            o_rot.rot_end_y == OUT_HI || o_rot.rot_end_y == OUT_LO ||
            o_rot.rot_end_z == OUT_HI || o_rot.rot_end_z == OUT_LO)
        else $error("clip flag set with no coordinate on a rail");

    a_cfg_sin_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == ler_pkg::REG_SIN_Z |=> r_sin[2] == $past(i_cfg_data))
        else $error("sine about Z not taken from the write port");

endmodule
`default_nettype wire
